@@ rtl/core/acit_pkg.sv @@
// Shared types and constants of the audio CPU interval timers.
// Used by the controller, the datapath and the top level. No dependencies.
package acit_pkg;

   localparam int TIMER_COUNT = 3;
   localparam int TIMER_IDX_W = 2;
   localparam int FAST_TIMER  = 2;
   localparam int SHIFT_W     = 4;
   localparam int SHIFT_MAX   = 8;
   localparam int TICK_W      = 11;
   localparam int TARGET_W    = 9;
   localparam int REM_W       = 8;
   localparam int CNT_W       = 4;
   localparam int DIV_BITS    = TICK_W;
   localparam int DIV_STEP_W  = 4;
   localparam int CSR_IDX_W   = 1;

   localparam logic [SHIFT_W-1:0]  SLOW_SHIFT_RESET = 4'd7;
   localparam logic [SHIFT_W-1:0]  FAST_SHIFT_RESET = 4'd4;
   localparam logic [TARGET_W-1:0] TARGET_FULL      = 9'h100;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_SHIFT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_SHIFT = 1'b1;

   typedef enum logic [1:0] {
      FUNC_ELAPSED = 2'd0,
      FUNC_CONTROL = 2'd1,
      FUNC_TARGET  = 2'd2,
      FUNC_READ    = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0] func;
      logic [1:0] timer_index;
      logic [7:0] write_data;
      logic [9:0] cycle_count;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] counter_value;
      logic [2:0] enable_mask;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_CTRL_WRITE,
      OP_TGT_WRITE,
      OP_ADVANCE,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_DIV_FINISH,
      OP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type              op;
      logic [TIMER_IDX_W-1:0] sel;
   } dp_cmd_type;

   typedef struct packed {
      func_type               func;
      logic [TIMER_IDX_W-1:0] idx;
      logic                   enabled;
      logic                   over;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ADVANCE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH,
      ST_RESPOND
   } ctrl_state_type;

   // Register value zero selects the full 256-tick period.
   function automatic logic [TARGET_W-1:0] target_of(input logic [7:0] reg_value);
      return (reg_value == 8'd0) ? TARGET_FULL : {1'b0, reg_value};
   endfunction

endpackage

@@ rtl/core/acit_datapath.sv @@
// Datapath of the interval timers: timer state, prescaler, serial divider
// for overflow counting, configuration registers and the result register. Uses acit_pkg.
module acit_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  acit_pkg::req_payload_type           req_payload,
   input  logic                                csr_write,
   input  logic [acit_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [acit_pkg::SHIFT_W-1:0]        csr_wdata,
   input  acit_pkg::dp_cmd_type                cmd,
   output acit_pkg::dp_status_type             status,
   output acit_pkg::rsp_payload_type           rsp_payload
);

   logic [acit_pkg::SHIFT_W-1:0]  slow_shift_ff, slow_shift_in;
   logic [acit_pkg::SHIFT_W-1:0]  fast_shift_ff, fast_shift_in;

   logic [acit_pkg::REM_W-1:0]    remainder_ff [acit_pkg::TIMER_COUNT];
   logic [acit_pkg::REM_W-1:0]    remainder_in [acit_pkg::TIMER_COUNT];
   logic [acit_pkg::TICK_W-1:0]   tick_ff      [acit_pkg::TIMER_COUNT];
   logic [acit_pkg::TICK_W-1:0]   tick_in      [acit_pkg::TIMER_COUNT];
   logic [acit_pkg::TARGET_W-1:0] latched_ff   [acit_pkg::TIMER_COUNT];
   logic [acit_pkg::TARGET_W-1:0] latched_in   [acit_pkg::TIMER_COUNT];
   logic [7:0]                    target_ff    [acit_pkg::TIMER_COUNT];
   logic [7:0]                    target_in    [acit_pkg::TIMER_COUNT];
   logic [acit_pkg::CNT_W-1:0]    counter_ff   [acit_pkg::TIMER_COUNT];
   logic [acit_pkg::CNT_W-1:0]    counter_in   [acit_pkg::TIMER_COUNT];
   logic [acit_pkg::TIMER_COUNT-1:0] enable_ff, enable_in;

   acit_pkg::req_payload_type     item_ff, item_in;
   acit_pkg::rsp_payload_type     rsp_ff, rsp_in;

   logic [acit_pkg::TARGET_W-1:0] div_rem_ff, div_rem_in;
   logic [acit_pkg::TICK_W-1:0]   div_dnd_ff, div_dnd_in;
   logic [acit_pkg::CNT_W-1:0]    div_quo_ff, div_quo_in;

   logic                          sel_ok;
   logic [acit_pkg::TIMER_IDX_W-1:0] sel;
   logic [acit_pkg::REM_W-1:0]    sel_rem;
   logic [acit_pkg::TICK_W-1:0]   sel_tick;
   logic [acit_pkg::TARGET_W-1:0] sel_latched;
   logic [acit_pkg::CNT_W-1:0]    sel_counter;
   logic                          sel_enabled;
   logic [acit_pkg::SHIFT_W-1:0]  shift_raw;
   logic [acit_pkg::SHIFT_W-1:0]  shift;
   logic [acit_pkg::TICK_W-1:0]   sum;
   logic [acit_pkg::TICK_W-1:0]   ticks;
   logic [acit_pkg::TICK_W-1:0]   mask;
   logic [acit_pkg::TARGET_W:0]   trial;
   logic                          trial_ge;
   logic [2:0]                    new_enables;

   assign sel    = cmd.sel;
   assign sel_ok = ({1'b0, sel} < 3'(acit_pkg::TIMER_COUNT));

   always_comb begin
      sel_rem     = '0;
      sel_tick    = '0;
      sel_latched = acit_pkg::TARGET_FULL;
      sel_counter = '0;
      sel_enabled = 1'b0;
      if (sel_ok) begin
         sel_rem     = remainder_ff[sel];
         sel_tick    = tick_ff[sel];
         sel_latched = latched_ff[sel];
         sel_counter = counter_ff[sel];
         sel_enabled = enable_ff[sel];
      end
   end

   // Prescaler: add the elapsed cycles to the remainder and split off whole ticks.
   always_comb begin
      shift_raw = (sel == acit_pkg::TIMER_IDX_W'(acit_pkg::FAST_TIMER)) ? fast_shift_ff
                                                                        : slow_shift_ff;
      shift = (shift_raw > acit_pkg::SHIFT_W'(acit_pkg::SHIFT_MAX))
            ? acit_pkg::SHIFT_W'(acit_pkg::SHIFT_MAX) : shift_raw;
      sum   = {3'b000, sel_rem} + {1'b0, item_ff.cycle_count};
      ticks = sum >> shift;
      mask  = (acit_pkg::TICK_W'(1) << shift) - acit_pkg::TICK_W'(1);
   end

   // One restoring division step: the quotient is the number of extra wraps.
   always_comb begin
      trial    = {div_rem_ff, div_dnd_ff[acit_pkg::TICK_W-1]};
      trial_ge = (trial >= {1'b0, sel_latched});
   end

   assign new_enables = item_ff.write_data[2:0];

   always_comb begin
      slow_shift_in = slow_shift_ff;
      fast_shift_in = fast_shift_ff;
      remainder_in  = remainder_ff;
      tick_in       = tick_ff;
      latched_in    = latched_ff;
      target_in     = target_ff;
      counter_in    = counter_ff;
      enable_in     = enable_ff;
      item_in       = item_ff;
      rsp_in        = rsp_ff;
      div_rem_in    = div_rem_ff;
      div_dnd_in    = div_dnd_ff;
      div_quo_in    = div_quo_ff;

      if (csr_write) begin
         unique case (csr_index)
            acit_pkg::CSR_SLOW_SHIFT: slow_shift_in = csr_wdata;
            acit_pkg::CSR_FAST_SHIFT: fast_shift_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (cmd.op)
         acit_pkg::OP_NOP: ;
         acit_pkg::OP_CAPTURE: item_in = req_payload;
         acit_pkg::OP_CTRL_WRITE: begin
            // A newly set enable restarts that timer.
            for (int t = 0; t < acit_pkg::TIMER_COUNT; t++) begin
               if (t < 3 && !enable_ff[t] && new_enables[t]) begin
                  remainder_in[t] = '0;
                  tick_in[t]      = '0;
                  counter_in[t]   = '0;
                  latched_in[t]   = acit_pkg::target_of(target_ff[t]);
               end
            end
            enable_in = acit_pkg::TIMER_COUNT'(new_enables);
         end
         acit_pkg::OP_TGT_WRITE: begin
            if (sel_ok) begin
               target_in[sel] = item_ff.write_data;
            end
         end
         acit_pkg::OP_ADVANCE: begin
            if (sel_ok) begin
               remainder_in[sel] = acit_pkg::REM_W'(sum & mask);
               tick_in[sel]      = sel_tick + ticks;
            end
         end
         acit_pkg::OP_DIV_START: begin
            div_rem_in = '0;
            div_quo_in = '0;
            div_dnd_in = sel_tick - acit_pkg::TICK_W'(1);
         end
         acit_pkg::OP_DIV_STEP: begin
            div_rem_in = trial_ge ? acit_pkg::TARGET_W'(trial - {1'b0, sel_latched})
                                  : acit_pkg::TARGET_W'(trial);
            div_quo_in = {div_quo_ff[acit_pkg::CNT_W-2:0], trial_ge};
            div_dnd_in = {div_dnd_ff[acit_pkg::TICK_W-2:0], 1'b0};
         end
         acit_pkg::OP_DIV_FINISH: begin
            if (sel_ok) begin
               tick_in[sel]    = acit_pkg::TICK_W'(div_rem_ff) + acit_pkg::TICK_W'(1);
               counter_in[sel] = sel_counter + div_quo_ff;
               latched_in[sel] = acit_pkg::target_of(target_ff[sel]);
            end
         end
         acit_pkg::OP_RESPOND: begin
            rsp_in.counter_value = sel_counter;
            rsp_in.enable_mask   = 3'(enable_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_shift_ff <= acit_pkg::SLOW_SHIFT_RESET;
         fast_shift_ff <= acit_pkg::FAST_SHIFT_RESET;
         enable_ff     <= '0;
         for (int t = 0; t < acit_pkg::TIMER_COUNT; t++) begin
            remainder_ff[t] <= '0;
            tick_ff[t]      <= '0;
            latched_ff[t]   <= acit_pkg::TARGET_FULL;
            target_ff[t]    <= '0;
            counter_ff[t]   <= '0;
         end
      end else begin
         slow_shift_ff <= slow_shift_in;
         fast_shift_ff <= fast_shift_in;
         enable_ff     <= enable_in;
         remainder_ff  <= remainder_in;
         tick_ff       <= tick_in;
         latched_ff    <= latched_in;
         target_ff     <= target_in;
         counter_ff    <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rsp_ff     <= rsp_in;
      div_rem_ff <= div_rem_in;
      div_dnd_ff <= div_dnd_in;
      div_quo_ff <= div_quo_in;
   end

   assign status.func    = acit_pkg::func_type'(item_ff.func);
   assign status.idx     = item_ff.timer_index;
   assign status.enabled = sel_enabled;
   assign status.over    = (sel_tick > {2'b00, sel_latched});
   assign rsp_payload    = rsp_ff;

endmodule

@@ rtl/core/acit_controller.sv @@
// Controller of the interval timers: sequences one item through the datapath,
// one timer at a time, and owns the handshake state. Uses acit_pkg.
module acit_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  acit_pkg::dp_status_type status,
   output acit_pkg::dp_cmd_type    cmd
);

   acit_pkg::ctrl_state_type           state_ff, state_in;
   logic [acit_pkg::TIMER_IDX_W-1:0]   timer_ff, timer_in;
   logic [acit_pkg::DIV_STEP_W-1:0]    step_ff, step_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               last_timer;
   logic                               out_free;

   assign last_timer = (timer_ff == acit_pkg::TIMER_IDX_W'(acit_pkg::TIMER_COUNT - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acit_pkg::ST_IDLE;
         timer_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timer_ff     <= timer_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      timer_in     = timer_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = acit_pkg::OP_NOP;
      cmd.sel      = timer_ff;
      req_stall    = 1'b1;

      unique case (state_ff)
         acit_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = acit_pkg::OP_CAPTURE;
               state_in = acit_pkg::ST_DISPATCH;
            end
         end
         acit_pkg::ST_DISPATCH: begin
            cmd.sel = status.idx;
            unique case (status.func)
               acit_pkg::FUNC_ELAPSED: begin
                  timer_in = '0;
                  state_in = acit_pkg::ST_ADVANCE;
               end
               acit_pkg::FUNC_CONTROL: begin
                  cmd.op   = acit_pkg::OP_CTRL_WRITE;
                  state_in = acit_pkg::ST_RESPOND;
               end
               acit_pkg::FUNC_TARGET: begin
                  cmd.op   = acit_pkg::OP_TGT_WRITE;
                  state_in = acit_pkg::ST_RESPOND;
               end
               acit_pkg::FUNC_READ: state_in = acit_pkg::ST_RESPOND;
               default: state_in = acit_pkg::ST_RESPOND;
            endcase
         end
         acit_pkg::ST_ADVANCE: begin
            if (status.enabled) begin
               cmd.op   = acit_pkg::OP_ADVANCE;
               state_in = acit_pkg::ST_CHECK;
            end else if (last_timer) begin
               state_in = acit_pkg::ST_RESPOND;
            end else begin
               timer_in = timer_ff + acit_pkg::TIMER_IDX_W'(1);
            end
         end
         acit_pkg::ST_CHECK: begin
            if (status.over) begin
               cmd.op   = acit_pkg::OP_DIV_START;
               step_in  = '0;
               state_in = acit_pkg::ST_DIVIDE;
            end else if (last_timer) begin
               state_in = acit_pkg::ST_RESPOND;
            end else begin
               timer_in = timer_ff + acit_pkg::TIMER_IDX_W'(1);
               state_in = acit_pkg::ST_ADVANCE;
            end
         end
         acit_pkg::ST_DIVIDE: begin
            cmd.op  = acit_pkg::OP_DIV_STEP;
            step_in = step_ff + acit_pkg::DIV_STEP_W'(1);
            if (step_ff == acit_pkg::DIV_STEP_W'(acit_pkg::DIV_BITS - 1)) begin
               state_in = acit_pkg::ST_FINISH;
            end
         end
         acit_pkg::ST_FINISH: begin
            cmd.op = acit_pkg::OP_DIV_FINISH;
            if (last_timer) begin
               state_in = acit_pkg::ST_RESPOND;
            end else begin
               timer_in = timer_ff + acit_pkg::TIMER_IDX_W'(1);
               state_in = acit_pkg::ST_ADVANCE;
            end
         end
         acit_pkg::ST_RESPOND: begin
            cmd.sel = status.idx;
            // The result register may still hold the previous item's result.
            if (out_free) begin
               cmd.op       = acit_pkg::OP_RESPOND;
               rsp_valid_in = 1'b1;
               state_in     = acit_pkg::ST_IDLE;
            end
         end
         default: state_in = acit_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/audio_cpu_interval_timers_core.sv @@
// Three interval timers of a sound CPU with prescalers and 4-bit output counters.
// Instantiates acit_controller and acit_datapath; uses acit_pkg.
//
// One item is worked on at a time and every item gives exactly one result, which waits
// in an output register so the next item can be taken while it is unclaimed. Control
// write, target write and counter read items go from dispatch straight to the result.
// An elapsed-cycles item visits each of the three timers in turn: a disabled timer is
// skipped, an enabled one is advanced and checked, and one that overflows is divided.
// The overflow case is set by an 11-step restoring divider, one quotient bit per cycle,
// shared by the timers, which turns any number of target periods into one update of the
// tick count and output counter.
module audio_cpu_interval_timers_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  acit_pkg::req_payload_type      req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output acit_pkg::rsp_payload_type      rsp_payload,
   input  logic                           csr_write,
   input  logic [acit_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [acit_pkg::SHIFT_W-1:0]   csr_wdata
);

   acit_pkg::dp_cmd_type    cmd;
   acit_pkg::dp_status_type status;

   acit_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   acit_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for audio_cpu_interval_timers_core: directed table, then random phases.
// Keeps its own timer predictor and checks each result in order. Depends on acit_pkg and the RTL.
module tb_top;
   import acit_pkg::*;

   localparam int PHASES         = 6;
   localparam int ITEMS_PER_PHASE = 285;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 60;

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   logic                   csr_write;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [SHIFT_W-1:0]     csr_wdata;

   // Predicted timer state.
   logic [REM_W-1:0]       phase_rem  [TIMER_COUNT];
   logic [TICK_W-1:0]      tick_total [TIMER_COUNT];
   logic [TARGET_W-1:0]    period_now [TIMER_COUNT];
   logic [7:0]             period_reg [TIMER_COUNT];
   logic [CNT_W-1:0]       wrap_cnt   [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] run_mask;
   logic [SHIFT_W-1:0]     slow_shift_m;
   logic [SHIFT_W-1:0]     fast_shift_m;

   rsp_payload_type        readout_q [$];
   dir_row_type            dir_rows [$];
   rsp_payload_type        got_want;
   int                     mismatch_count = 0;
   int                     items_sent     = 0;
   int                     results_seen   = 0;
   int                     idle_cycles    = 0;
   int                     send_idle_pct  = 0;
   int                     rsp_stall_pct  = 0;
   int                     hold_budget    = 0;
   int                     phase_slow [PHASES] = '{7, 0, 8, 15, 2, 5};
   int                     phase_fast [PHASES] = '{4, 8, 0, 9, 1, 12};
   int                     phase_idle [PHASES] = '{0, 74, 0, 30, 0, 30};
   int                     phase_stall [PHASES] = '{0, 0, 74, 30, 0, 30};

   audio_cpu_interval_timers_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [TARGET_W-1:0] period_from_reg(input logic [7:0] value);
      return (value == 8'd0) ? TARGET_FULL : {1'b0, value};
   endfunction

   task automatic clear_timer_model();
      for (int t = 0; t < TIMER_COUNT; t++) begin
         phase_rem[t]  = '0;
         tick_total[t] = '0;
         period_now[t] = TARGET_FULL;
         period_reg[t] = '0;
         wrap_cnt[t]   = '0;
      end
      run_mask     = '0;
      slow_shift_m = SLOW_SHIFT_RESET;
      fast_shift_m = FAST_SHIFT_RESET;
   endtask

   // Applies one item to the predicted state and returns the readout it should produce.
   function automatic rsp_payload_type next_timer_readout(input req_payload_type item);
      rsp_payload_type        r;
      int unsigned            sh;
      int unsigned            total;
      logic                   wrapped;
      logic [TIMER_COUNT-1:0] new_mask;
      case (func_type'(item.func))
         FUNC_ELAPSED: begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
               if (run_mask[t]) begin
                  sh = (t == FAST_TIMER) ? 32'(fast_shift_m) : 32'(slow_shift_m);
                  if (sh > SHIFT_MAX) sh = SHIFT_MAX;
                  total = 32'(phase_rem[t]) + 32'(item.cycle_count);
                  phase_rem[t] = REM_W'(total & ((1 << sh) - 1));
                  total = 32'(tick_total[t]) + (total >> sh);
                  wrapped = 1'b0;
                  while (total > period_now[t]) begin
                     total = total - period_now[t];
                     wrap_cnt[t] = wrap_cnt[t] + 1'b1;
                     wrapped = 1'b1;
                  end
                  tick_total[t] = TICK_W'(total);
                  if (wrapped) period_now[t] = period_from_reg(period_reg[t]);
               end
            end
         end
         FUNC_CONTROL: begin
            new_mask = item.write_data[TIMER_COUNT-1:0];
            for (int t = 0; t < TIMER_COUNT; t++) begin
               // A timer switched on restarts from zero with a fresh period.
               if (!run_mask[t] && new_mask[t]) begin
                  phase_rem[t]  = '0;
                  tick_total[t] = '0;
                  wrap_cnt[t]   = '0;
                  period_now[t] = period_from_reg(period_reg[t]);
               end
            end
            run_mask = new_mask;
         end
         FUNC_TARGET: begin
            if (item.timer_index < TIMER_COUNT) period_reg[item.timer_index] = item.write_data;
         end
         default: ;
      endcase
      r.counter_value = (item.timer_index < TIMER_COUNT) ? wrap_cnt[item.timer_index] : '0;
      r.enable_mask   = run_mask;
      return r;
   endfunction

   function automatic dir_row_type row(input func_type f, input logic [1:0] idx,
                                       input logic [7:0] data, input logic [9:0] cycles,
                                       input bit typed, input logic [3:0] cnt,
                                       input logic [2:0] mask);
      dir_row_type d;
      d.item.func          = f;
      d.item.timer_index   = idx;
      d.item.write_data    = data;
      d.item.cycle_count   = cycles;
      d.typed              = typed;
      d.want.counter_value = cnt;
      d.want.enable_mask   = mask;
      return d;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at result %0d: %s", results_seen, msg);
      mismatch_count++;
   endtask

   // Called just after a falling edge; returns just after the falling edge that follows
   // acceptance.
   task automatic send_item(input req_payload_type item, input bit typed,
                            input rsp_payload_type want);
      rsp_payload_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = next_timer_readout(item);
      readout_q.push_back(typed ? want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (readout_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_prescalers(input logic [SHIFT_W-1:0] slow, input logic [SHIFT_W-1:0] fast);
      csr_write <= 1'b1;
      csr_index <= CSR_SLOW_SHIFT;
      csr_wdata <= slow;
      @(negedge clock);
      csr_index <= CSR_FAST_SHIFT;
      csr_wdata <= fast;
      @(negedge clock);
      csr_write <= 1'b0;
      slow_shift_m = slow;
      fast_shift_m = fast;
   endtask

   // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_budget > 0) begin
            rsp_stall <= 1'b1;
            hold_budget--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (readout_q.size() == 0) begin
               report_mismatch("result arrived with nothing expected");
            end else begin
               got_want = readout_q.pop_front();
               if (rsp_payload.counter_value !== got_want.counter_value)
                  report_mismatch($sformatf("counter_value got %0d expected %0d",
                                            rsp_payload.counter_value, got_want.counter_value));
               if (rsp_payload.enable_mask !== got_want.enable_mask)
                  report_mismatch($sformatf("enable_mask got %0h expected %0h",
                                            rsp_payload.enable_mask, got_want.enable_mask));
            end
            results_seen++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("audio_cpu_interval_timers_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      req_payload_type item;
      rsp_payload_type none;
      int              pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      none        = '0;
      clear_timer_model();

      // Shifts are at their reset values (7 slow, 4 fast) for this table.
      dir_rows.push_back(row(FUNC_READ,    2'd0, 8'h00, 10'd0,    1'b1, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_READ,    2'd3, 8'h00, 10'd0,    1'b1, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_TARGET,  2'd3, 8'hff, 10'd0,    1'b1, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_ELAPSED, 2'd0, 8'h00, 10'd1023, 1'b1, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_CONTROL, 2'd0, 8'hf8, 10'd0,    1'b1, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_TARGET,  2'd0, 8'h01, 10'd0,    1'b1, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_TARGET,  2'd1, 8'hff, 10'd0,    1'b1, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_TARGET,  2'd2, 8'h00, 10'd0,    1'b1, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_CONTROL, 2'd2, 8'hff, 10'd0,    1'b1, 4'd0, 3'd7));
      dir_rows.push_back(row(FUNC_ELAPSED, 2'd0, 8'h00, 10'd1023, 1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_ELAPSED, 2'd2, 8'h00, 10'd1023, 1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_READ,    2'd0, 8'h00, 10'd0,    1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_READ,    2'd1, 8'h00, 10'd0,    1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_READ,    2'd2, 8'h00, 10'd0,    1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_READ,    2'd0, 8'h00, 10'd0,    1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_CONTROL, 2'd1, 8'h05, 10'd0,    1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_ELAPSED, 2'd1, 8'h00, 10'd1023, 1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_CONTROL, 2'd1, 8'h07, 10'd0,    1'b1, 4'd0, 3'd7));
      dir_rows.push_back(row(FUNC_TARGET,  2'd0, 8'h80, 10'd0,    1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_ELAPSED, 2'd0, 8'h00, 10'd0,    1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_ELAPSED, 2'd0, 8'h00, 10'd1,    1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_ELAPSED, 2'd2, 8'h00, 10'd1023, 1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_CONTROL, 2'd3, 8'h00, 10'd0,    1'b1, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_ELAPSED, 2'd2, 8'h00, 10'd1023, 1'b0, 4'd0, 3'd0));
      dir_rows.push_back(row(FUNC_READ,    2'd3, 8'h00, 10'd0,    1'b1, 4'd0, 3'd0));

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         if (p == PHASES - 1) begin
            phase_slow[p] = $urandom_range(15);
            phase_fast[p] = $urandom_range(15);
         end
         set_prescalers(SHIFT_W'(phase_slow[p]), SHIFT_W'(phase_fast[p]));
         send_idle_pct = phase_idle[p];
         rsp_stall_pct = phase_stall[p];
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Phase four holds results back long enough for the block to fill up.
            if (p == 4 && i == 20) hold_budget = HOLD_OFF_CYCLES;
            pick = $urandom_range(99);
            item.func = (pick < 50) ? FUNC_ELAPSED : (pick < 62) ? FUNC_CONTROL :
                        (pick < 77) ? FUNC_TARGET : FUNC_READ;
            item.timer_index = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            item.write_data  = 8'($urandom_range(255));
            item.cycle_count = 10'($urandom_range(1023));
            case ($urandom_range(7))
               0: item.cycle_count = 10'd0;
               1: item.cycle_count = 10'd1023;
               2: item.cycle_count = 10'($urandom_range(15));
               default: ;
            endcase
            if (item.func == FUNC_TARGET) begin
               case ($urandom_range(5))
                  0: item.write_data = 8'h00;
                  1: item.write_data = 8'h01;
                  2: item.write_data = 8'hff;
                  3: item.write_data = 8'($urandom_range(7));
                  default: ;
               endcase
            end
            // Mostly keep every timer running so the counters get deep into their cycle.
            if (item.func == FUNC_CONTROL && $urandom_range(9) < 6) item.write_data[2:0] = 3'b111;
            send_item(item, 1'b0, none);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Sent %0d items over %0d prescaler settings, %0d results checked,",
               items_sent, PHASES + 1, results_seen);
      $display("including a %0d-cycle result hold-off that backed up the input.",
               HOLD_OFF_CYCLES);
      if (mismatch_count == 0 && readout_q.size() == 0) begin
         $display("audio_cpu_interval_timers_core verification clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, readout_q.size());
         $display("audio_cpu_interval_timers_core verification failed");
      end
      $finish;
   end

endmodule
